>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes and field widths of the text console writer: action codes,
// control characters and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// field widths of the transaction payload
	localparam int unsigned ACT_W  = 3;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned TCOL_W = 7;
	localparam int unsigned TROW_W = 6;
	localparam int unsigned COLS_W = 8;
	localparam int unsigned ROWS_W = 7;
	localparam int unsigned ATTR_W = 8;
	localparam int unsigned CELL_W = CHAR_W + ATTR_W;
	localparam int unsigned CFGI_W = 2;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [CFGI_W-1:0] cfg_index_t;

	// actions
	localparam action_t ACT_WRITE_CHAR = 3'd0;
	localparam action_t ACT_SET_CURSOR = 3'd1;
	localparam action_t ACT_PUT_AT     = 3'd2;
	localparam action_t ACT_CLEAR      = 3'd3;
	localparam action_t ACT_READ_CELL  = 3'd4;

	// control characters
	localparam char_t CH_TAB   = 8'd9;
	localparam char_t CH_LF    = 8'd10;
	localparam char_t CH_CR    = 8'd13;
	localparam char_t CH_SPACE = 8'd32;

	// configuration register indexes
	localparam cfg_index_t CFG_COLUMNS = 2'd0;
	localparam cfg_index_t CFG_ROWS    = 2'd1;
	localparam cfg_index_t CFG_ATTR    = 2'd2;

	// geometry after reset
	localparam logic [COLS_W-1:0] RESET_COLUMNS = 8'd80;
	localparam logic [ROWS_W-1:0] RESET_ROWS    = 7'd25;

endpackage

`default_nettype wire

>>> rtl/core/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: a cell store of character/attribute pairs held
// in one synchronous memory, a cursor, and a sequencer that walks the store
// for scrolls, clears and tab runs.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  command  | start / busy            | action, char_code, target_col, target_row
//  result   | done (one-cycle strobe) | ok, cell_char, cell_attr, cursor_col, cursor_row
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  A command transaction is taken when start is high and busy is low; one
//  result follows. Scrolling and clearing walk the store one cell per cycle
//  through the single write port; a scroll holds while its last copy drains.
//  After reset a clearing pass zeroes all MAX_COLUMNS * MAX_ROWS cells with
//  busy high. Results cannot be held off; config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core
	import tcw_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = 128,
	parameter int unsigned MAX_ROWS    = 64,
	parameter int unsigned TAB_WIDTH   = 8
) (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	// command
	input  wire  logic              start,
	output logic                    busy,
	input  wire  logic [ACT_W-1:0]  action,
	input  wire  logic [CHAR_W-1:0] char_code,
	input  wire  logic [TCOL_W-1:0] target_col,
	input  wire  logic [TROW_W-1:0] target_row,
	// result
	output logic                    done,
	output logic                    ok,
	output logic [CHAR_W-1:0]       cell_char,
	output logic [ATTR_W-1:0]       cell_attr,
	output logic [COLS_W-1:0]       cursor_col,
	output logic [TROW_W-1:0]       cursor_row,
	// configuration
	input  wire  logic              cfg_valid,
	output logic                    cfg_ready,
	input  wire  logic [CFGI_W-1:0] cfg_index,
	input  wire  logic [COLS_W-1:0] cfg_data
);

	localparam int unsigned CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int unsigned AW  = $clog2(CELL_COUNT);
	localparam int unsigned AW1 = $clog2(CELL_COUNT + 1);
	localparam int unsigned PW  = COLS_W + ROWS_W;

	localparam logic [COLS_W-1:0] COL_CAP = (MAX_COLUMNS > 255) ? 8'd255 : COLS_W'(MAX_COLUMNS);
	localparam logic [ROWS_W-1:0] ROW_CAP = (MAX_ROWS > 127) ? 7'd127 : ROWS_W'(MAX_ROWS);
	localparam logic [COLS_W-1:0] TAB_LEN = COLS_W'(TAB_WIDTH);
	localparam logic [AW-1:0]     LAST_CELL = AW'(CELL_COUNT - 1);

	// sequencer states
	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_COPY  = 3'd4;
	localparam logic [2:0] ST_BLANK = 3'd5;
	localparam logic [2:0] ST_CHAR  = 3'd6;
	localparam logic [2:0] ST_TAB   = 3'd7;

	// tab stop map over every column value, worked out at elaboration
	function automatic logic [255:0] tab_stop_map();
		logic [255:0] m;
		m = '0;
		for (int i = 0; i < 256; i++) begin
			m[i] = ((i % TAB_WIDTH) == 0);
		end
		return m;
	endfunction

	localparam logic [255:0] TAB_STOP = tab_stop_map();

	function automatic logic [COLS_W-1:0] clamp_cols(logic [COLS_W-1:0] v);
		logic [COLS_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = COLS_W'(1);
		end else if (v > COL_CAP) begin
			r = COL_CAP;
		end
		return r;
	endfunction

	function automatic logic [ROWS_W-1:0] clamp_rows(logic [ROWS_W-1:0] v);
		logic [ROWS_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = ROWS_W'(1);
		end else if (v > ROW_CAP) begin
			r = ROW_CAP;
		end
		return r;
	endfunction

	// registers
	logic [2:0]        state_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic [ATTR_W-1:0] attr_q;
	logic [COLS_W-1:0] x_q;
	logic [ROWS_W-1:0] y_q;
	logic [AW-1:0]     ptr_q;
	logic              more_q;
	logic              done_q;
	logic              ok_q;
	logic [CELL_W-1:0] cell_q;
	char_t             ch_q;
	logic              pend_s1;
	logic [AW-1:0]     waddr_s1;

	// memory
	cell_t             mem [CELL_COUNT];
	cell_t             rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	cell_t             mem_wdata;
	logic [AW-1:0]     mem_raddr;

	// geometry
	logic [COLS_W-1:0] cu;
	logic [ROWS_W-1:0] ru;
	logic [PW-1:0]     area_full;
	logic [AW1-1:0]    area;
	logic [AW1-1:0]    area_last;
	logic [AW1-1:0]    ptr_ext;

	// cell addressing
	logic [COLS_W-1:0] a_col;
	logic [ROWS_W-1:0] a_row;
	logic [PW-1:0]     row_base;
	logic [PW:0]       addr_full;
	logic [AW-1:0]     cell_addr;

	// decode helpers
	logic              in_range;
	logic [COLS_W:0]   y_next;
	logic              row_wraps;
	logic              at_edge;
	logic              tab_near_edge;
	logic [COLS_W-1:0] cols_new;
	logic [ROWS_W-1:0] rows_new;

	assign cu        = clamp_cols(cols_q);
	assign ru        = clamp_rows(rows_q);
	assign area_full = PW'(cu) * PW'(ru);
	assign area      = AW1'(area_full);
	assign area_last = area - AW1'(1);
	assign ptr_ext   = AW1'(ptr_q);

	assign a_col     = (state_q == ST_IDLE) ? COLS_W'(target_col) : x_q;
	assign a_row     = (state_q == ST_IDLE) ? ROWS_W'(target_row) : y_q;
	assign row_base  = PW'(a_row) * PW'(cu);
	assign addr_full = (PW+1)'(row_base) + (PW+1)'(a_col);
	assign cell_addr = AW'(addr_full);

	assign in_range      = (COLS_W'(target_col) < cu) && (ROWS_W'(target_row) < ru);
	assign y_next        = (COLS_W+1)'(y_q) + (COLS_W+1)'(1);
	assign row_wraps     = y_next >= (COLS_W+1)'(ru);
	assign at_edge       = x_q >= cu;
	assign tab_near_edge = (cu - x_q) < TAB_LEN;
	assign cols_new      = clamp_cols(cfg_data);
	assign rows_new      = clamp_rows(ROWS_W'(cfg_data));

	// select the single write of this cycle; a pending scroll copy wins
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr;
		mem_wdata = {attr_q, ch_q};
		mem_raddr = (state_q == ST_IDLE) ? cell_addr : ptr_q;
		if (pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = rd_q;
		end else begin
			case (state_q)
				ST_SWEEP, ST_CLEAR, ST_BLANK: begin
					mem_we    = 1'b1;
					mem_waddr = ptr_q;
					mem_wdata = '0;
				end
				ST_IDLE: begin
					mem_we    = start && (action == ACT_PUT_AT) && in_range;
					mem_wdata = {attr_q, char_code};
				end
				ST_CHAR: begin
					mem_we = (ch_q != CH_TAB);
				end
				ST_TAB: begin
					mem_we    = !TAB_STOP[x_q] && !tab_near_edge;
					mem_wdata = {attr_q, CH_SPACE};
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	// cell store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// scroll copy pipeline: write back in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_COPY);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= AW'(ptr_q - AW'(cu));
	end

	// sequencer, cursor and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			cols_q  <= RESET_COLUMNS;
			rows_q  <= RESET_ROWS;
			attr_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			ptr_q   <= '0;
			more_q  <= 1'b0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			cell_q  <= '0;
			ch_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_SWEEP: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (start) begin
						ch_q   <= char_code;
						cell_q <= '0;
						ok_q   <= 1'b1;
						case (action)
							ACT_WRITE_CHAR: begin
								if (char_code == CH_CR) begin
									x_q    <= '0;
									done_q <= 1'b1;
								end else if (at_edge || char_code == CH_LF) begin
									// move to the next row, scrolling past the bottom
									x_q <= '0;
									if (row_wraps) begin
										more_q  <= (char_code != CH_LF);
										state_q <= (ru > ROWS_W'(1)) ? ST_COPY : ST_BLANK;
										ptr_q   <= (ru > ROWS_W'(1)) ? AW'(cu) : '0;
									end else begin
										y_q <= ROWS_W'(y_next);
										if (char_code == CH_LF) begin
											done_q <= 1'b1;
										end else begin
											state_q <= ST_CHAR;
										end
									end
								end else begin
									state_q <= ST_CHAR;
								end
							end
							ACT_SET_CURSOR: begin
								ok_q   <= in_range;
								done_q <= 1'b1;
								if (in_range) begin
									x_q <= COLS_W'(target_col);
									y_q <= ROWS_W'(target_row);
								end
							end
							ACT_PUT_AT: begin
								ok_q   <= in_range;
								done_q <= 1'b1;
							end
							ACT_CLEAR: begin
								ptr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							ACT_READ_CELL: begin
								ok_q <= in_range;
								if (in_range) begin
									state_q <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								ok_q   <= 1'b0;
								done_q <= 1'b1;
							end
						endcase
					end
				end

				ST_READ: begin
					cell_q  <= rd_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end

				ST_CLEAR: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_ext == area_last) begin
						x_q     <= '0;
						y_q     <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				ST_COPY: begin
					if (ptr_ext == area_last) begin
						ptr_q   <= AW'(area - AW1'(cu));
						state_q <= ST_BLANK;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end

				ST_BLANK: begin
					// hold while the last copy drains through the write port
					if (!pend_s1) begin
						ptr_q <= ptr_q + AW'(1);
						if (ptr_ext == area_last) begin
							if (more_q) begin
								state_q <= ST_CHAR;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
					end
				end

				ST_CHAR: begin
					if (ch_q == CH_TAB) begin
						if (x_q == '0) begin
							x_q <= COLS_W'(1);
						end
						state_q <= ST_TAB;
					end else begin
						x_q     <= x_q + COLS_W'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				ST_TAB: begin
					if (TAB_STOP[x_q]) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (tab_near_edge) begin
						// wrap to the next row and drop the rest of the run
						x_q    <= '0;
						more_q <= 1'b0;
						if (row_wraps) begin
							state_q <= (ru > ROWS_W'(1)) ? ST_COPY : ST_BLANK;
							ptr_q   <= (ru > ROWS_W'(1)) ? AW'(cu) : '0;
						end else begin
							y_q     <= ROWS_W'(y_next);
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						x_q <= x_q + COLS_W'(1);
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// configuration transaction: saturate the cursor to the new geometry
			if (cfg_valid) begin
				case (cfg_index)
					CFG_COLUMNS: begin
						cols_q <= cfg_data;
						if (x_q > cols_new) begin
							x_q <= cols_new;
						end
					end
					CFG_ROWS: begin
						rows_q <= ROWS_W'(cfg_data);
						if (y_q >= rows_new) begin
							y_q <= rows_new - ROWS_W'(1);
						end
					end
					CFG_ATTR: begin
						attr_q <= cfg_data;
					end
					default: begin
						attr_q <= attr_q;
					end
				endcase
			end
		end
	end

	// ports
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign ok         = ok_q;
	assign cell_char  = cell_q[CHAR_W-1:0];
	assign cell_attr  = cell_q[CELL_W-1:CHAR_W];
	assign cursor_col = x_q;
	assign cursor_row = y_q[TROW_W-1:0];

endmodule

`default_nettype wire

>>> tb/tb_text_console_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console engine. A short directed table
// covers the reset state, out-of-range targets, unused actions, tabs,
// wraps and scrolls. Random commands follow over a series of screen
// geometries and attributes, from one cell up to the full store. Every result
// is checked against its table reply or a cycle-free cursor and cell model.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;
	import tcw_pkg::*;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int TAB_WIDTH   = 8;
	localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
	// slowest legal run: reset clear, every command a full scroll at its
	// geometry, plus sender gaps; then several times over
	localparam int unsigned CYCLE_LIMIT  = 4000000;
	// longest operation left in the final small geometry, with margin
	localparam int unsigned DRAIN_CYCLES = 256;
	localparam int unsigned PRINT_LIMIT  = 100;

	// action codes with no meaning
	localparam action_t ACT_UNUSED_LO  = 3'd5;
	localparam action_t ACT_UNUSED_MID = 3'd6;
	localparam action_t ACT_UNUSED_HI  = 3'd7;

	typedef struct packed {
		action_t             act;
		char_t               ch;
		logic [TCOL_W-1:0]   col;
		logic [TROW_W-1:0]   row;
	} console_cmd_t;

	typedef struct packed {
		logic                ok;
		char_t               ch;
		logic [ATTR_W-1:0]   attr;
		logic [COLS_W-1:0]   col;
		logic [TROW_W-1:0]   row;
	} console_reply_t;

	typedef struct packed {
		console_cmd_t        cmd;
		logic                fixed;
		console_reply_t      reply;
	} directed_row_t;

	typedef struct packed {
		logic [7:0]          cols;
		logic [7:0]          rows;
		logic [7:0]          attr;
		logic [15:0]         items;
	} screen_setup_t;

	localparam console_reply_t NO_REPLY = '0;

	// directed commands at the reset geometry (80 x 25, attribute 0)
	localparam directed_row_t DIRECTED_TBL [26] = '{
		'{'{ACT_READ_CELL,  8'h00, 7'd0,   6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_READ_CELL,  8'h00, 7'd79,  6'd24}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_READ_CELL,  8'h00, 7'd80,  6'd0},  1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_READ_CELL,  8'h00, 7'd0,   6'd25}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_SET_CURSOR, 8'h00, 7'd127, 6'd63}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_PUT_AT,     8'h55, 7'd80,  6'd24}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_UNUSED_LO,  8'hFF, 7'd127, 6'd63}, 1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_UNUSED_MID, 8'h41, 7'd1,   6'd1},  1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_UNUSED_HI,  8'h00, 7'd0,   6'd0},  1'b1, '{1'b0, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_WRITE_CHAR, 8'h41, 7'd0,   6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd1,  6'd0}},
		'{'{ACT_PUT_AT,     8'hFF, 7'd79,  6'd24}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'd1,  6'd0}},
		'{'{ACT_READ_CELL,  8'h00, 7'd79,  6'd24}, 1'b1, '{1'b1, 8'hFF, 8'h00, 8'd1,  6'd0}},
		'{'{ACT_WRITE_CHAR, 8'h00, 7'd127, 6'd63}, 1'b0, NO_REPLY},
		'{'{ACT_WRITE_CHAR, CH_TAB, 7'd0,  6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd8,  6'd0}},
		'{'{ACT_WRITE_CHAR, CH_TAB, 7'd0,  6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd8,  6'd0}},
		'{'{ACT_READ_CELL,  8'h00, 7'd5,   6'd0},  1'b0, NO_REPLY},
		'{'{ACT_WRITE_CHAR, CH_CR, 7'd0,   6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd0}},
		'{'{ACT_WRITE_CHAR, CH_TAB, 7'd0,  6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd8,  6'd0}},
		'{'{ACT_WRITE_CHAR, CH_LF, 7'd0,   6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd1}},
		'{'{ACT_SET_CURSOR, 8'h00, 7'd78,  6'd24}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'd78, 6'd24}},
		'{'{ACT_WRITE_CHAR, CH_TAB, 7'd0,  6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd24}},
		'{'{ACT_READ_CELL,  8'h00, 7'd79,  6'd23}, 1'b0, NO_REPLY},
		'{'{ACT_SET_CURSOR, 8'h00, 7'd79,  6'd24}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'd79, 6'd24}},
		'{'{ACT_WRITE_CHAR, 8'h80, 7'd0,   6'd0},  1'b1, '{1'b1, 8'h00, 8'h00, 8'd80, 6'd24}},
		'{'{ACT_WRITE_CHAR, 8'h7F, 7'd0,   6'd0},  1'b0, NO_REPLY},
		'{'{ACT_CLEAR,      8'hFF, 7'd127, 6'd63}, 1'b1, '{1'b1, 8'h00, 8'h00, 8'd0,  6'd0}}
	};

	// fixed geometries, extremes among them; random ones follow
	localparam screen_setup_t FIXED_SETUPS [8] = '{
		'{8'd8,   8'd4,   8'h1F, 16'd300},
		'{8'd1,   8'd1,   8'hFF, 16'd150},
		'{8'd0,   8'd0,   8'h00, 16'd100},
		'{8'd13,  8'd3,   8'hA5, 16'd250},
		'{8'd128, 8'd64,  8'h5A, 16'd40},
		'{8'd255, 8'd255, 8'h3C, 16'd40},
		'{8'd17,  8'd8,   8'hF0, 16'd250},
		'{8'd24,  8'd2,   8'h0F, 16'd200}
	};
	localparam int RANDOM_SETUPS = 4;
	localparam int RANDOM_ITEMS  = 170;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ACT_W-1:0]    action;
	logic [CHAR_W-1:0]   char_code;
	logic [TCOL_W-1:0]   target_col;
	logic [TROW_W-1:0]   target_row;
	logic                done;
	logic                ok;
	logic [CHAR_W-1:0]   cell_char;
	logic [ATTR_W-1:0]   cell_attr;
	logic [COLS_W-1:0]   cursor_col;
	logic [TROW_W-1:0]   cursor_row;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFGI_W-1:0]   cfg_index;
	logic [COLS_W-1:0]   cfg_data;

	// console model state
	logic [COLS_W-1:0]   geo_cols;
	logic [ROWS_W-1:0]   geo_rows;
	logic [ATTR_W-1:0]   cur_attr;
	int                  pos_x;
	int                  pos_y;
	logic [CELL_W-1:0]   shadow_cells [CELL_COUNT];

	console_reply_t      pending_replies [$];
	logic                drive_fixed;
	console_reply_t      drive_reply;
	int unsigned         mismatch_count;
	int unsigned         cycle_count;

	text_console_writer_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.char_code  (char_code),
		.target_col (target_col),
		.target_row (target_row),
		.done       (done),
		.ok         (ok),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ---------------------------------------------------------------- model

	function automatic int cols_in_use();
		if (geo_cols == 0) return 1;
		if (int'(geo_cols) > MAX_COLUMNS) return MAX_COLUMNS;
		return int'(geo_cols);
	endfunction

	function automatic int rows_in_use();
		if (geo_rows == 0) return 1;
		if (int'(geo_rows) > MAX_ROWS) return MAX_ROWS;
		return int'(geo_rows);
	endfunction

	function automatic void store_at(int x, int y, char_t c);
		int idx;
		idx = x + y * cols_in_use();
		if (idx < CELL_COUNT) shadow_cells[idx] = {cur_attr, c};
	endfunction

	// move every row up by one, blank the bottom row
	function automatic void scroll_one_row();
		int c;
		int r;
		int i;
		c = cols_in_use();
		r = rows_in_use();
		if (pos_y > 0) pos_y--;
		for (i = 0; i < c * (r - 1); i++) shadow_cells[i] = shadow_cells[i + c];
		for (i = 0; i < c; i++) shadow_cells[c * (r - 1) + i] = '0;
	endfunction

	function automatic void line_feed();
		pos_x = 0;
		pos_y++;
		if (pos_y >= rows_in_use()) scroll_one_row();
	endfunction

	function automatic void type_char(char_t c);
		int w;
		w = cols_in_use();
		if (c == CH_CR) begin
			pos_x = 0;
			return;
		end
		// wrap at the right edge, or on newline
		if (pos_x >= w || c == CH_LF) begin
			line_feed();
			if (c == CH_LF) return;
		end
		if (c == CH_TAB) begin
			if (pos_x == 0) pos_x = 1;
			while (pos_x % TAB_WIDTH != 0) begin
				if (w - pos_x < TAB_WIDTH) begin
					line_feed();
					break;
				end
				store_at(pos_x, pos_y, CH_SPACE);
				pos_x++;
			end
		end else begin
			store_at(pos_x, pos_y, c);
			pos_x++;
		end
	endfunction

	// saturate the cursor into a shrunk screen
	function automatic void clamp_cursor();
		if (pos_x > cols_in_use()) pos_x = cols_in_use();
		if (pos_y >= rows_in_use()) pos_y = rows_in_use() - 1;
	endfunction

	function automatic void apply_register(cfg_index_t idx, logic [COLS_W-1:0] data);
		case (idx)
			CFG_COLUMNS: begin
				geo_cols = data;
				clamp_cursor();
			end
			CFG_ROWS: begin
				geo_rows = data[ROWS_W-1:0];
				clamp_cursor();
			end
			CFG_ATTR: cur_attr = data;
			default: ;
		endcase
	endfunction

	function automatic console_reply_t console_step(console_cmd_t cmd);
		console_reply_t r;
		logic           hit;
		int             idx;
		int             i;
		r = '0;
		hit = int'(cmd.col) < cols_in_use() && int'(cmd.row) < rows_in_use();
		case (cmd.act)
			ACT_WRITE_CHAR: begin
				type_char(cmd.ch);
				r.ok = 1'b1;
			end
			ACT_SET_CURSOR: if (hit) begin
				pos_x = int'(cmd.col);
				pos_y = int'(cmd.row);
				r.ok = 1'b1;
			end
			ACT_PUT_AT: if (hit) begin
				store_at(int'(cmd.col), int'(cmd.row), cmd.ch);
				r.ok = 1'b1;
			end
			ACT_CLEAR: begin
				for (i = 0; i < cols_in_use() * rows_in_use(); i++) shadow_cells[i] = '0;
				pos_x = 0;
				pos_y = 0;
				r.ok = 1'b1;
			end
			ACT_READ_CELL: if (hit) begin
				idx = int'(cmd.col) + int'(cmd.row) * cols_in_use();
				if (idx < CELL_COUNT) {r.attr, r.ch} = shadow_cells[idx];
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.col = pos_x[COLS_W-1:0];
		r.row = pos_y[TROW_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------- checking

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
				cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// take results first, then predict the transaction accepted on this edge
	always @(posedge clk) begin : check_results
		console_reply_t want;
		console_cmd_t   seen;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want = pending_replies.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", 32'(ok), 32'(want.ok));
				if (cell_char !== want.ch)
					report_mismatch("cell_char", 32'(cell_char), 32'(want.ch));
				if (cell_attr !== want.attr)
					report_mismatch("cell_attr", 32'(cell_attr), 32'(want.attr));
				if (cursor_col !== want.col)
					report_mismatch("cursor_col", 32'(cursor_col), 32'(want.col));
				if (cursor_row !== want.row)
					report_mismatch("cursor_row", 32'(cursor_row), 32'(want.row));
			end
		end
		if (arst_n && start && !busy) begin
			seen = '{action, char_code, target_col, target_row};
			want = console_step(seen);
			pending_replies.push_back(drive_fixed ? drive_reply : want);
		end
	end

	// ------------------------------------------------------------- stimulus

	task automatic issue_command(console_cmd_t cmd, logic fixed, console_reply_t reply,
			int unsigned gap);
		if (gap != 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		action     <= cmd.act;
		char_code  <= cmd.ch;
		target_col <= cmd.col;
		target_row <= cmd.row;
		drive_fixed = fixed;
		drive_reply = reply;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_replies.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_register(cfg_index_t idx, logic [COLS_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_register(idx, data);
	endtask

	task automatic load_setup(screen_setup_t s);
		write_register(CFG_COLUMNS, s.cols);
		write_register(CFG_ROWS, s.rows);
		write_register(CFG_ATTR, s.attr);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly console text with some cursor work; targets mostly on screen
	function automatic console_cmd_t random_command();
		console_cmd_t c;
		int unsigned  w;
		c.ch  = CHAR_W'($urandom);
		c.col = TCOL_W'($urandom);
		c.row = TROW_W'($urandom);
		w = $urandom_range(0, 99);
		if (w < 48) c.act = ACT_WRITE_CHAR;
		else if (w < 56) begin
			c.act = ACT_WRITE_CHAR;
			c.ch = CH_TAB;
		end else if (w < 63) begin
			c.act = ACT_WRITE_CHAR;
			c.ch = CH_LF;
		end else if (w < 67) begin
			c.act = ACT_WRITE_CHAR;
			c.ch = CH_CR;
		end else if (w < 76) c.act = ACT_SET_CURSOR;
		else if (w < 84) c.act = ACT_PUT_AT;
		else if (w < 97) c.act = ACT_READ_CELL;
		else if (w < 99) c.act = ACT_CLEAR;
		else c.act = action_t'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		if (c.act != ACT_WRITE_CHAR && $urandom_range(0, 4) != 0) begin
			c.col = TCOL_W'($urandom_range(0, cols_in_use()));
			c.row = TROW_W'($urandom_range(0, rows_in_use()));
		end
		return c;
	endfunction

	// bursts of back-to-back commands separated by random gaps
	task automatic run_random(int unsigned count);
		int unsigned burst_left;
		int unsigned gap;
		burst_left = 0;
		repeat (count) begin
			gap = 0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			end
			burst_left--;
			issue_command(random_command(), 1'b0, NO_REPLY, gap);
		end
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin : main_flow
		screen_setup_t s;
		int            i;
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = '0;
		char_code   = '0;
		target_col  = '0;
		target_row  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		drive_fixed = 1'b0;
		drive_reply = NO_REPLY;
		mismatch_count = 0;
		cycle_count    = 0;
		geo_cols = RESET_COLUMNS;
		geo_rows = RESET_ROWS;
		cur_attr = '0;
		pos_x    = 0;
		pos_y    = 0;
		for (i = 0; i < CELL_COUNT; i++) shadow_cells[i] = '0;

		// hold reset, then release it away from the clock edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table at the reset geometry
		for (i = 0; i < $size(DIRECTED_TBL); i++)
			issue_command(DIRECTED_TBL[i].cmd, DIRECTED_TBL[i].fixed, DIRECTED_TBL[i].reply,
				$urandom_range(0, 2));

		// random commands over fixed, then random, geometries
		for (i = 0; i < $size(FIXED_SETUPS) + RANDOM_SETUPS; i++) begin
			if (i < $size(FIXED_SETUPS)) begin
				s = FIXED_SETUPS[i];
			end else begin
				s.cols  = 8'($urandom_range(1, 24));
				s.rows  = 8'($urandom_range(1, 8));
				s.attr  = 8'($urandom);
				s.items = 16'(RANDOM_ITEMS);
			end
			wait_idle();
			load_setup(s);
			run_random(32'(s.items));
		end

		// drain, then allow for a late spurious result
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
